>>> hw/rtl/dltq_pkg.sv
// Shared types and codes of the delta-list task timer queue.
package dltq_pkg;

   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_TICK     = 2'd1,
      OP_DISPATCH = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   localparam int TAG_W  = 16;
   localparam int RUNS_W = 8;
   localparam int MS_W   = 32;
   localparam int CNT_W  = 5;

   typedef struct packed {
      logic load_req;
      logic div_step;
      logic div_load;
      logic walk_init;
      logic walk_adv;
      logic wr_cur_sub;
      logic wr_prev_link;
      logic wr_new;
      logic set_slot;
      logic set_full;
      logic cur_head;
      logic tick_wr;
      logic tick_adv;
      logic pop;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic free_any;
      logic head_none;
      logic walk_stop;
      logic next_none;
      logic tick_more;
      logic runs_zero;
      logic period_zero;
   } sts_type;

endpackage

>>> hw/rtl/dltq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dltq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/dltq_ctrl.sv
// Sequencer of the delta-list task timer queue.
module dltq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [1:0]       req_op,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output dltq_pkg::cmd_type cmd,
   input  dltq_pkg::sts_type sts
);
   import dltq_pkg::*;

   typedef enum logic [15:0] {
      ST_IDLE     = 16'h0001,
      ST_DIV      = 16'h0002,
      ST_DIV_FIN  = 16'h0004,
      ST_ADD_INIT = 16'h0008,
      ST_ADD_WAIT = 16'h0010,
      ST_ADD_CHK  = 16'h0020,
      ST_ADD_FIX  = 16'h0040,
      ST_ADD_LINK = 16'h0080,
      ST_ADD_NEW  = 16'h0100,
      ST_TK_INIT  = 16'h0200,
      ST_TK_WAIT  = 16'h0400,
      ST_TK_CHK   = 16'h0800,
      ST_DP_INIT  = 16'h1000,
      ST_DP_WAIT  = 16'h2000,
      ST_DP_CHK   = 16'h4000,
      ST_DONE     = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      readd_ff, readd_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      readd_in = readd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               readd_in     = 1'b0;
               unique case (op_type'(req_op))
                  OP_ADD:      state_in = ST_DIV;
                  OP_TICK:     state_in = ST_TK_INIT;
                  OP_DISPATCH: state_in = ST_DP_INIT;
                  OP_NONE:     state_in = ST_DONE;
               endcase
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_DIV_FIN;
            end
         end
         ST_DIV_FIN: begin
            cmd.div_load = 1'b1;
            state_in     = ST_ADD_INIT;
         end
         ST_ADD_INIT: begin
            if (!sts.free_any) begin
               cmd.set_full = !readd_ff;
               state_in     = ST_DONE;
            end else begin
               cmd.walk_init = 1'b1;
               state_in      = sts.head_none ? ST_ADD_NEW : ST_ADD_WAIT;
            end
         end
         ST_ADD_WAIT: state_in = ST_ADD_CHK;
         ST_ADD_CHK: begin
            if (sts.walk_stop) begin
               state_in = ST_ADD_FIX;
            end else begin
               cmd.walk_adv = 1'b1;
               state_in     = sts.next_none ? ST_ADD_LINK : ST_ADD_WAIT;
            end
         end
         ST_ADD_FIX: begin
            cmd.wr_cur_sub = 1'b1;
            state_in       = ST_ADD_LINK;
         end
         ST_ADD_LINK: begin
            cmd.wr_prev_link = 1'b1;
            state_in         = ST_ADD_NEW;
         end
         ST_ADD_NEW: begin
            cmd.wr_new   = 1'b1;
            cmd.set_slot = !readd_ff;
            state_in     = ST_DONE;
         end
         ST_TK_INIT: begin
            if (sts.head_none) begin
               state_in = ST_DONE;
            end else begin
               cmd.cur_head = 1'b1;
               state_in     = ST_TK_WAIT;
            end
         end
         ST_TK_WAIT: state_in = ST_TK_CHK;
         ST_TK_CHK: begin
            cmd.tick_wr = 1'b1;
            if (sts.tick_more) begin
               cmd.tick_adv = 1'b1;
               state_in     = ST_TK_WAIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DP_INIT: begin
            if (sts.head_none) begin
               state_in = ST_DONE;
            end else begin
               cmd.cur_head = 1'b1;
               state_in     = ST_DP_WAIT;
            end
         end
         ST_DP_WAIT: state_in = ST_DP_CHK;
         ST_DP_CHK: begin
            if (sts.runs_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.pop = 1'b1;
               if (sts.period_zero) begin
                  state_in = ST_DONE;
               end else begin
                  readd_in = 1'b1;
                  state_in = ST_ADD_INIT;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         readd_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         readd_ff     <= readd_in;
      end
   end
endmodule

>>> hw/rtl/dltq_dp.sv
// Datapath of the delta-list task timer queue: slot table, list walk and divider.
module dltq_dp #(
   parameter int SLOTS   = 8,
   parameter int TICK_MS = 10,
   parameter int SW      = $clog2(SLOTS + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [15:0]              req_tag,
   input  logic [31:0]              req_delay,
   input  logic [31:0]              req_period,
   input  dltq_pkg::cmd_type        cmd,
   output dltq_pkg::sts_type        sts,
   output logic [SW-1:0]            out_slot,
   output logic                     out_run_valid,
   output logic [15:0]              out_run_tag
);
   import dltq_pkg::*;

   localparam longint QMAX = 64'hFFFFFFFF / TICK_MS;
   localparam int DW   = $clog2(QMAX + 1);
   localparam int AW   = $clog2(SLOTS);
   localparam int LW   = $clog2(TICK_MS);
   localparam int SH   = MS_W + LW;
   localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
   localparam logic [15:0] RC_LO = RECIP[15:0];
   localparam logic [16:0] RC_HI = RECIP[32:16];
   localparam int PW   = MS_W + 17;
   localparam int AC_W = MS_W + 33;
   localparam int REC_W = TAG_W + 2 * DW + RUNS_W + SW;
   localparam int NXT_L = 0;
   localparam int RUN_L = SW;
   localparam int PER_L = SW + RUNS_W;
   localparam int DEL_L = PER_L + DW;
   localparam int TAG_L = DEL_L + DW;
   localparam logic [SW-1:0] NONE = SW'(SLOTS);

   logic [SLOTS-1:0]  used_ff, used_in;
   logic [SW-1:0]     head_ff, head_in;
   logic [SW-1:0]     cur_ff, cur_in;
   logic [SW-1:0]     prev_ff, prev_in;
   logic [SW-1:0]     new_ff, new_in;
   logic [REC_W-1:0]  prev_rec_ff, prev_rec_in;
   logic [DW-1:0]     d_ff, d_in;
   logic [DW-1:0]     p_ff, p_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic              first_ff, first_in;
   logic [MS_W-1:0]   xd_ff, xd_in, xp_ff, xp_in;
   logic [AC_W-1:0]   ad_ff, ad_in, ap_ff, ap_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SW-1:0]     res_slot_ff, res_slot_in;
   logic              res_rv_ff, res_rv_in;
   logic [TAG_W-1:0]  res_tag_ff, res_tag_in;
   logic [SW-1:0]     o_slot_ff, o_slot_in;
   logic              o_rv_ff, o_rv_in;
   logic [TAG_W-1:0]  o_tag_ff, o_tag_in;

   logic [REC_W-1:0]  rdata, wdata;
   logic              we;
   logic [SW-1:0]     waddr;
   logic [SW-1:0]     free_idx;
   logic              free_any;
   logic [SW-1:0]     c_next;
   logic [RUNS_W-1:0] c_runs, c_runs_inc;
   logic [DW-1:0]     c_per, c_del, nd;
   logic [TAG_W-1:0]  c_tag;
   logic [16:0]       coef;
   logic [PW-1:0]     pd, pp;

   dltq_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr[AW-1:0]),
      .wr_data (wdata),
      .rd_addr (cur_ff[AW-1:0]),
      .rd_data (rdata)
   );

   assign c_next = rdata[NXT_L +: SW];
   assign c_runs = rdata[RUN_L +: RUNS_W];
   assign c_per  = rdata[PER_L +: DW];
   assign c_del  = rdata[DEL_L +: DW];
   assign c_tag  = rdata[TAG_L +: TAG_W];
   assign c_runs_inc = (c_runs == '1) ? c_runs : c_runs + RUNS_W'(1);
   assign nd = (first_ff && c_del != '0) ? c_del - DW'(1) : c_del;

   always_comb begin
      free_idx = NONE;
      free_any = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx = SW'(i);
            free_any = 1'b1;
         end
      end
   end

   // reciprocal multiply: low coefficient half first, high half second
   assign coef = cnt_ff[0] ? RC_HI : {1'b0, RC_LO};
   assign pd   = PW'(xd_ff) * PW'(coef);
   assign pp   = PW'(xp_ff) * PW'(coef);

   always_comb begin
      sts.div_last    = (cnt_ff == CNT_W'(1));
      sts.free_any    = free_any;
      sts.head_none   = (head_ff == NONE);
      sts.walk_stop   = (d_ff < c_del);
      sts.next_none   = (c_next == NONE);
      sts.tick_more   = (nd == '0) && (c_next != NONE);
      sts.runs_zero   = (c_runs == '0);
      sts.period_zero = (c_per == '0);
   end

   always_comb begin
      we    = 1'b0;
      waddr = cur_ff;
      wdata = rdata;
      priority if (cmd.wr_cur_sub) begin
         we    = 1'b1;
         wdata = {c_tag, c_del - d_ff, c_per, c_runs, c_next};
      end else if (cmd.wr_prev_link) begin
         we    = (prev_ff != NONE);
         waddr = prev_ff;
         wdata = {prev_rec_ff[REC_W-1:SW], new_ff};
      end else if (cmd.wr_new) begin
         we    = 1'b1;
         waddr = new_ff;
         wdata = {tag_ff, d_ff, p_ff, RUNS_W'(0), cur_ff};
      end else if (cmd.tick_wr) begin
         we    = first_ff || (nd == '0);
         wdata = {c_tag, nd, c_per, (nd == '0) ? c_runs_inc : c_runs, c_next};
      end
   end

   always_comb begin
      used_in     = used_ff;
      head_in     = head_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      new_in      = new_ff;
      prev_rec_in = prev_rec_ff;
      d_in        = d_ff;
      p_in        = p_ff;
      tag_in      = tag_ff;
      first_in    = first_ff;
      xd_in       = xd_ff;
      xp_in       = xp_ff;
      ad_in       = ad_ff;
      ap_in       = ap_ff;
      cnt_in      = cnt_ff;
      res_slot_in = res_slot_ff;
      res_rv_in   = res_rv_ff;
      res_tag_in  = res_tag_ff;
      o_slot_in   = o_slot_ff;
      o_rv_in     = o_rv_ff;
      o_tag_in    = o_tag_ff;
      if (cmd.load_req) begin
         tag_in      = req_tag;
         xd_in       = req_delay;
         xp_in       = req_period;
         cnt_in      = '0;
         res_slot_in = '0;
         res_rv_in   = 1'b0;
         res_tag_in  = '0;
      end
      if (cmd.div_step) begin
         if (cnt_ff[0]) begin
            ad_in = ad_ff + (AC_W'(pd) << 16);
            ap_in = ap_ff + (AC_W'(pp) << 16);
         end else begin
            ad_in = AC_W'(pd);
            ap_in = AC_W'(pp);
         end
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.div_load) begin
         d_in = DW'(ad_ff >> SH);
         p_in = DW'(ap_ff >> SH);
      end
      if (cmd.walk_init) begin
         cur_in  = head_ff;
         prev_in = NONE;
         new_in  = free_idx;
      end
      if (cmd.walk_adv) begin
         prev_in     = cur_ff;
         prev_rec_in = rdata;
         cur_in      = c_next;
         d_in        = d_ff - c_del;
      end
      if (cmd.wr_new) begin
         used_in[new_ff[AW-1:0]] = 1'b1;
         if (prev_ff == NONE) begin
            head_in = new_ff;
         end
      end
      if (cmd.set_slot) begin
         res_slot_in = new_ff;
      end
      if (cmd.set_full) begin
         res_slot_in = NONE;
      end
      if (cmd.cur_head) begin
         cur_in   = head_ff;
         first_in = 1'b1;
      end
      if (cmd.tick_adv) begin
         cur_in   = c_next;
         first_in = 1'b0;
      end
      if (cmd.pop) begin
         head_in                 = c_next;
         used_in[cur_ff[AW-1:0]] = 1'b0;
         res_rv_in               = 1'b1;
         res_tag_in              = c_tag;
         tag_in                  = c_tag;
         d_in                    = c_per;
         p_in                    = c_per;
      end
      if (cmd.out_load) begin
         o_slot_in = res_slot_ff;
         o_rv_in   = res_rv_ff;
         o_tag_in  = res_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         head_ff <= NONE;
      end else begin
         used_ff <= used_in;
         head_ff <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      new_ff      <= new_in;
      prev_rec_ff <= prev_rec_in;
      d_ff        <= d_in;
      p_ff        <= p_in;
      tag_ff      <= tag_in;
      first_ff    <= first_in;
      xd_ff       <= xd_in;
      xp_ff       <= xp_in;
      ad_ff       <= ad_in;
      ap_ff       <= ap_in;
      cnt_ff      <= cnt_in;
      res_slot_ff <= res_slot_in;
      res_rv_ff   <= res_rv_in;
      res_tag_ff  <= res_tag_in;
      o_slot_ff   <= o_slot_in;
      o_rv_ff     <= o_rv_in;
      o_tag_ff    <= o_tag_in;
   end

   assign out_slot      = o_slot_ff;
   assign out_run_valid = o_rv_ff;
   assign out_run_tag   = o_tag_ff;
endmodule

>>> hw/rtl/delta_list_task_timer_queue.sv
// Top level of the delta-list task timer queue.
// Use: send one request per transfer on the req_ channel; req_tuser carries the
// operation (add, tick, dispatch or none), req_tdata the tag, delay and period in ms.
// Every request returns exactly one transfer on the rsp_ channel: the slot taken
// by an add (SLOTS when full), or run_valid and run_tag for a dispatch.
// What each request does, walking the list entry by entry:
//   add: a reciprocal multiply, low coefficient half then high half, scales
//        delay and period to ticks; the walk then finds the entry's place, and
//        when it lands before another entry, that entry's delta is cut first;
//        a full table ends the add at once, an empty list skips the walk.
//   tick: lowers the head's delta, walks on while entries reach zero delta.
//   dispatch: pops the head if it has runs left; a repeating task is re-added in
//        the same request by the add walk; an empty list ends at once.
// Each visited entry waits for the registered read of the slot RAM.
// One request is in work at a time; req_tready is high only while idle, so a new
// request is taken only once the last one's result is in the output register.
// A finished result sits in the output register; the next request is taken
// while it waits, but its own result holds until rsp_tready frees that register.
// Reset empties the list and frees all slots at once; no clearing pass.
module delta_list_task_timer_queue #(
   parameter int SLOTS   = 8,
   parameter int TICK_MS = 10,
   parameter int SW      = $clog2(SLOTS + 1),
   parameter int RSP_W   = ((SW + 17 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [79:0]      req_tdata,  // task_tag[15:0], delay[47:16], period[79:48]
   input  logic [1:0]       req_tuser,  // op[1:0]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // slot, run_valid, run_tag, zero fill
);
   import dltq_pkg::*;

   cmd_type       cmd;
   sts_type       sts;
   logic [SW-1:0] out_slot;
   logic          out_run_valid;
   logic [15:0]   out_run_tag;

   dltq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   dltq_dp #(.SLOTS(SLOTS), .TICK_MS(TICK_MS), .SW(SW)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_tag       (req_tdata[15:0]),
      .req_delay     (req_tdata[47:16]),
      .req_period    (req_tdata[79:48]),
      .cmd           (cmd),
      .sts           (sts),
      .out_slot      (out_slot),
      .out_run_valid (out_run_valid),
      .out_run_tag   (out_run_tag)
   );

   assign rsp_tdata = RSP_W'({out_run_tag, out_run_valid, out_slot});
endmodule
